// ----- rtl/scb_pkg.sv -----
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types, constants and tables for the scan context builder.
// ----------------------------------------------------------------------------
`default_nettype none

package scb_pkg;

    localparam int MAX_RINGS_DEFAULT   = 32;
    localparam int MAX_SECTORS_DEFAULT = 64;

    localparam int HEIGHT_W  = 19;
    localparam int COORD_W   = 20;
    localparam int RADIUS_W  = 19;
    localparam int PHASE_W   = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 19;

    localparam int CORDIC_STEPS = 14;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_RING_COUNT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SECTOR_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RADIUS   = 2'd2;

    // Operation codes carried in the input tuser.
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SQ1,
        S_SQ2,
        S_LHS,
        S_RMUL,
        S_RCMP,
        S_ANG,
        S_SEC,
        S_ADR,
        S_RD,
        S_UPD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // Angle of each vectoring step, 65536 = one full turn.
    function automatic logic [13:0] step_angle(input logic [3:0] idx);
        logic [13:0] a;
        unique case (idx)
            4'd0:    a = 14'd8192;
            4'd1:    a = 14'd4836;
            4'd2:    a = 14'd2555;
            4'd3:    a = 14'd1297;
            4'd4:    a = 14'd651;
            4'd5:    a = 14'd326;
            4'd6:    a = 14'd163;
            4'd7:    a = 14'd81;
            4'd8:    a = 14'd41;
            4'd9:    a = 14'd20;
            4'd10:   a = 14'd10;
            4'd11:   a = 14'd5;
            4'd12:   a = 14'd3;
            4'd13:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/scb_ram.sv -----
// ----------------------------------------------------------------------------
// scb_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- rtl/scb_cordic.sv -----
// ----------------------------------------------------------------------------
// scb_cordic
// Iterative vectoring unit: 16-bit phase of the direction of (-x, -y).
// ----------------------------------------------------------------------------
`default_nettype none

module scb_cordic
    import scb_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [COORD_W-1:0] x_in,
    input  wire logic signed [COORD_W-1:0] y_in,
    output cordic_stat_t                   stat,
    output logic         [PHASE_W-1:0]     phase
);

    localparam int VW = 32;

    logic signed [COORD_W:0]   nx, ny;
    logic signed [COORD_W+1:0] ua, va;
    logic [1:0]                quad;

    logic signed [VW-1:0] u_reg, v_reg;
    logic signed [16:0]   z_reg;
    logic [1:0]           quad_reg;
    logic [3:0]           step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic signed [VW-1:0] du, dv;
    logic signed [16:0]   ang;
    logic [13:0]          zc;

    // Remove the quadrant by exact quarter turns.
    always_comb begin
        nx = -$signed({x_in[COORD_W-1], x_in});
        ny = -$signed({y_in[COORD_W-1], y_in});
        if (nx > 0 && ny >= 0) begin
            quad = 2'd0; ua = (COORD_W+2)'(nx);  va = (COORD_W+2)'(ny);
        end else if (nx <= 0 && ny > 0) begin
            quad = 2'd1; ua = (COORD_W+2)'(ny);  va = -(COORD_W+2)'(nx);
        end else if (nx < 0 && ny <= 0) begin
            quad = 2'd2; ua = -(COORD_W+2)'(nx); va = -(COORD_W+2)'(ny);
        end else begin
            quad = 2'd3; ua = -(COORD_W+2)'(ny); va = (COORD_W+2)'(nx);
        end
    end

    assign du  = v_reg >>> step_reg;
    assign dv  = u_reg >>> step_reg;
    assign ang = $signed({3'b000, step_angle(step_reg)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
            u_reg    <= VW'(ua) <<< 8;
            v_reg    <= VW'(va) <<< 8;
            z_reg    <= '0;
            quad_reg <= quad;
        end else if (busy_reg) begin
            if (v_reg > 0) begin
                u_reg <= u_reg + du;
                v_reg <= v_reg - dv;
                z_reg <= z_reg + ang;
            end else begin
                u_reg <= u_reg - du;
                v_reg <= v_reg + dv;
                z_reg <= z_reg - ang;
            end
            if (step_reg == 4'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                step_reg <= step_reg + 4'd1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_comb begin
        if (z_reg < 0) begin
            zc = '0;
        end else if (z_reg > 17'sd16383) begin
            zc = 14'h3FFF;
        end else begin
            zc = z_reg[13:0];
        end
    end

    assign phase     = {quad_reg, zc};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/scan_context_builder.sv -----
// ----------------------------------------------------------------------------
// scan_context_builder
// Polar height grid (scan context) built from a stream of points.
// ----------------------------------------------------------------------------
// Points and cell reads enter on the s_ stream, one transaction each; every
// input transaction yields exactly one result transaction on the m_ stream.
// s_tuser selects the operation: accumulate a point or read and clear a cell.
// Configuration writes arrive on the cfg_ channel, which is always ready; they
// are meant to be made while the block is idle.
// The block works on one item at a time. An accumulate passes through the
// squaring of the coordinates, a binary search over the ring index with one
// multiply and one compare per bit, and a 14-step angle unit started in
// parallel that sets the pace at the default size, then a read and write back
// of the grid memory. A read goes through the read and write back alone, or
// straight to the result for a select outside the store; a skipped point
// leaves after the squaring. The next input transaction can be taken in the
// cycle after the result is delivered. After reset the grid memory is cleared
// one cell per cycle, all MAX_RINGS*MAX_SECTORS cells (2048 by default);
// s_tready stays low meanwhile.
// A result waits in the output register while m_tready is low, and no new
// input transaction is taken until it has been delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_context_builder
    import scb_pkg::*;
#(
    parameter int MAX_RINGS   = MAX_RINGS_DEFAULT,
    parameter int MAX_SECTORS = MAX_SECTORS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: x_mm[19:0], y_mm[39:20], z_mm[59:40], ring_select[64:60],
    //        sector_select[70:65], zero[71]
    input  wire logic [71:0]           s_tdata,
    // tuser: operation
    input  wire logic                  s_tuser,
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata: ring_index[4:0], sector_index[10:5], cell_height[29:11], zero[31:30]
    output logic [31:0]                m_tdata,
    // tuser: accepted
    output logic                       m_tuser,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_RINGS * MAX_SECTORS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int RW    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int BW    = (RW > 1) ? $clog2(RW) : 1;
    localparam int SW    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int RCW   = $clog2(MAX_RINGS + 1);
    localparam int SCW   = $clog2(MAX_SECTORS + 1);
    localparam int R2W   = 2 * COORD_W;
    localparam int LIMW  = 2 * RADIUS_W;
    localparam int LHSW  = R2W + 2 * RCW;
    localparam int MW    = RW + RADIUS_W;
    localparam int MSQW  = 2 * MW;
    localparam int CMPW  = (MSQW > LHSW) ? MSQW : LHSW;

    // Configuration registers.
    logic [5:0]          ring_count_reg;
    logic [6:0]          sector_count_reg;
    logic [RADIUS_W-1:0] max_radius_reg;

    // Sequencer and datapath registers.
    state_t state_reg, state_next;
    logic                       op_reg;
    logic signed [COORD_W-1:0]  x_reg, y_reg, z_reg;
    logic [4:0]                 rsel_reg;
    logic [5:0]                 ssel_reg;
    logic [R2W-2:0]             xx_reg, yy_reg;
    logic [LIMW-1:0]            lim_reg;
    logic [2*RCW-1:0]           rr_reg;
    logic [R2W-1:0]             r2_reg;
    logic [LHSW-1:0]            lhs_reg;
    logic [MW-1:0]              m_reg;
    logic [RW-1:0]              ring_reg;
    logic [BW-1:0]              bit_reg;
    logic [SW-1:0]              sector_reg;
    logic [AW-1:0]              addr_reg;
    logic [CNTW-1:0]            clr_reg;

    logic                       out_valid_reg;
    logic                       out_acc_reg;
    logic [4:0]                 out_ring_reg;
    logic [5:0]                 out_sec_reg;
    logic [HEIGHT_W-1:0]        out_h_reg;

    // Combinational helpers.
    logic [RCW-1:0]             rings_eff;
    logic [SCW-1:0]             sectors_eff;
    logic                       in_accept;
    logic                       in_range;
    logic                       skip;
    logic [RW-1:0]              trial;
    logic [MSQW-1:0]            msq;
    logic                       ring_fits;
    logic [PHASE_W+SCW-1:0]     psc;
    logic [SCW-1:0]             sector_raw;
    logic [SCW-1:0]             sector_clamped;
    logic [HEIGHT_W-1:0]        old_h;
    logic [HEIGHT_W-1:0]        new_h;
    logic [2*COORD_W-1:0]       xx_full, yy_full;
    logic signed [2*COORD_W-1:0] xs_full, ys_full;
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [HEIGHT_W-1:0]        ram_wdata;
    logic                       cordic_start;
    cordic_stat_t               cst;
    logic [PHASE_W-1:0]         phase;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_count_reg   <= 6'd20;
            sector_count_reg <= 7'd60;
            max_radius_reg   <= 19'd80000;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_RING_COUNT:   ring_count_reg   <= cfg_data[5:0];
                REG_SECTOR_COUNT: sector_count_reg <= cfg_data[6:0];
                REG_MAX_RADIUS:   max_radius_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (ring_count_reg == '0) begin
            rings_eff = RCW'(1);
        end else if (int'(ring_count_reg) > MAX_RINGS) begin
            rings_eff = RCW'(MAX_RINGS);
        end else begin
            rings_eff = RCW'(ring_count_reg);
        end
        if (sector_count_reg == '0) begin
            sectors_eff = SCW'(1);
        end else if (int'(sector_count_reg) > MAX_SECTORS) begin
            sectors_eff = SCW'(MAX_SECTORS);
        end else begin
            sectors_eff = SCW'(sector_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = (int'(s_tdata[64:60]) < MAX_RINGS)
                    && (int'(s_tdata[70:65]) < MAX_SECTORS);

    assign xs_full = x_reg * x_reg;
    assign ys_full = y_reg * y_reg;
    assign xx_full = xs_full;
    assign yy_full = ys_full;

    assign skip  = (r2_reg == '0) || (r2_reg >= R2W'(lim_reg));
    assign trial = ring_reg | (RW'(1) << bit_reg);
    assign msq   = m_reg * m_reg;
    assign ring_fits = CMPW'(msq) <= CMPW'(lhs_reg);

    assign psc        = phase * sectors_eff;
    assign sector_raw = psc[PHASE_W+SCW-1:PHASE_W];
    assign sector_clamped = (sector_raw > sectors_eff - SCW'(1))
                          ? sectors_eff - SCW'(1) : sector_raw;

    // A read clears; only a positive z above the stored maximum replaces it.
    always_comb begin
        if (op_reg == OP_READ) begin
            new_h = '0;
        end else if (!z_reg[COORD_W-1] && (z_reg != '0)
                     && (z_reg[HEIGHT_W-1:0] > old_h)) begin
            new_h = z_reg[HEIGHT_W-1:0];
        end else begin
            new_h = old_h;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_reg == CNTW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (in_accept) begin
                    if (s_tuser == OP_READ) begin
                        state_next = in_range ? S_RD : S_OUT;
                    end else begin
                        state_next = S_SQ1;
                    end
                end
            end
            S_SQ1:  state_next = S_SQ2;
            S_SQ2:  state_next = S_LHS;
            S_LHS:  state_next = skip ? S_OUT : S_RMUL;
            S_RMUL: state_next = S_RCMP;
            S_RCMP: state_next = (bit_reg == '0) ? S_ANG : S_RMUL;
            S_ANG:  if (!cst.busy) state_next = S_SEC;
            S_SEC:  state_next = S_ADR;
            S_ADR:  state_next = S_RD;
            S_RD:   state_next = S_UPD;
            S_UPD:  state_next = S_OUT;
            S_OUT:  if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = addr_reg;
        ram_wdata    = new_h;
        cordic_start = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[AW-1:0];
                ram_wdata = '0;
            end
            S_IDLE: s_tready     = 1'b1;
            S_SQ1:  cordic_start = 1'b1;
            S_UPD:  ram_we       = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLR) begin
                clr_reg <= clr_reg + CNTW'(1);
            end
            if (state_reg == S_OUT && m_tready) begin
                out_valid_reg <= 1'b0;
            end else if (state_next == S_OUT && state_reg != S_OUT) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    op_reg   <= s_tuser;
                    x_reg    <= s_tdata[19:0];
                    y_reg    <= s_tdata[39:20];
                    z_reg    <= s_tdata[59:40];
                    rsel_reg <= s_tdata[64:60];
                    ssel_reg <= s_tdata[70:65];
                    addr_reg <= AW'(s_tdata[64:60]) * AW'(MAX_SECTORS)
                              + AW'(s_tdata[70:65]);
                    out_acc_reg  <= 1'b0;
                    out_ring_reg <= s_tdata[64:60];
                    out_sec_reg  <= s_tdata[70:65];
                    out_h_reg    <= '0;
                end
            end
            S_SQ1: begin
                xx_reg  <= xx_full[R2W-2:0];
                yy_reg  <= yy_full[R2W-2:0];
                lim_reg <= max_radius_reg * max_radius_reg;
                rr_reg  <= rings_eff * rings_eff;
            end
            S_SQ2: r2_reg <= R2W'(xx_reg) + R2W'(yy_reg);
            S_LHS: begin
                lhs_reg      <= LHSW'(r2_reg) * LHSW'(rr_reg);
                ring_reg     <= '0;
                bit_reg      <= BW'(RW - 1);
                out_acc_reg  <= 1'b0;
                out_ring_reg <= '0;
                out_sec_reg  <= '0;
                out_h_reg    <= '0;
            end
            S_RMUL: m_reg <= MW'(trial) * MW'(max_radius_reg);
            S_RCMP: begin
                if (ring_fits) begin
                    ring_reg <= trial;
                end
                if (bit_reg != '0) begin
                    bit_reg <= bit_reg - BW'(1);
                end
            end
            S_SEC: sector_reg <= SW'(sector_clamped);
            S_ADR: addr_reg   <= AW'(ring_reg) * AW'(MAX_SECTORS) + AW'(sector_reg);
            S_UPD: begin
                out_acc_reg <= 1'b1;
                out_h_reg   <= (op_reg == OP_READ) ? old_h : new_h;
                if (op_reg == OP_READ) begin
                    out_ring_reg <= rsel_reg;
                    out_sec_reg  <= ssel_reg;
                end else begin
                    out_ring_reg <= 5'(ring_reg);
                    out_sec_reg  <= 6'(sector_reg);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    scb_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (old_h)
    );

    scb_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_in    (x_reg),
        .y_in    (y_reg),
        .stat    (cst),
        .phase   (phase)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_acc_reg;
    assign m_tdata  = {2'b00, out_h_reg, out_sec_reg, out_ring_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while a result is pending");

    a_write_only_clear_or_update: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLR || state_reg == S_UPD))
        else $error("grid written outside clear or update");

    a_sector_after_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEC) |-> !cst.busy)
        else $error("sector taken before the angle unit finished");

    a_result_follows_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |=> m_tvalid && m_tuser)
        else $error("update did not produce an accepted result");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scan context builder.
// ----------------------------------------------------------------------------
// Drives accumulate and read transactions with random gaps on both streams.
// A local copy of the height grid and the three registers predicts each
// result. Results are compared field by field in order of acceptance.
// A short directed table comes first. Several random phases follow, each
// with its own register setting, and the extremes are among the settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import scb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RINGS   = MAX_RINGS_DEFAULT;
    localparam int NUM_SECTORS = MAX_SECTORS_DEFAULT;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic               op;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic [4:0]         rs;
        logic [5:0]         ss;
    } point_item_t;

    typedef struct {
        logic        accepted;
        logic [4:0]  ring;
        logic [5:0]  sector;
        logic [18:0] height;
    } cell_result_t;

    typedef struct {
        point_item_t  item;
        logic         typed;
        cell_result_t result;
    } table_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // tdata: x_mm, y_mm, z_mm, ring_select, sector_select, zero pad
    logic [71:0]           s_tdata;
    // tuser: operation
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // tdata: ring_index, sector_index, cell_height, zero pad
    logic [31:0]           m_tdata;
    // tuser: accepted
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    scan_context_builder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Model state.
    logic [18:0]   grid_model [NUM_RINGS*NUM_SECTORS];
    logic [5:0]    model_rings;
    logic [6:0]    model_sectors;
    logic [18:0]   model_radius;
    cell_result_t  pending_cells [$];
    int            error_count = 0;
    bit            quiet_mode = 0;
    bit            long_hold = 0;
    longint        cycle_count = 0;

    const longint turn_steps [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1};

    // Direction of (u, v) as a 16-bit phase.
    function automatic longint phase_of(longint u, longint v);
        longint t, du, dv, acc;
        longint quad;
        acc = 0;
        if (u > 0 && v >= 0) begin
            quad = 0;
        end else if (u <= 0 && v > 0) begin
            t = u; u = v; v = -t; quad = 1;
        end else if (u < 0 && v <= 0) begin
            u = -u; v = -v; quad = 2;
        end else begin
            t = u; u = -v; v = t; quad = 3;
        end
        u = u * 256;
        v = v * 256;
        for (int i = 0; i < 14; i++) begin
            du = v >>> i;
            dv = u >>> i;
            if (v > 0) begin
                u += du; v -= dv; acc += turn_steps[i];
            end else begin
                u -= du; v += dv; acc -= turn_steps[i];
            end
        end
        if (acc < 0) acc = 0;
        if (acc > 16383) acc = 16383;
        return quad * 16384 + acc;
    endfunction

    function automatic cell_result_t predict_cell(point_item_t it);
        cell_result_t res;
        longint x, y, z, r2, lim, lhs, rings, sectors, ring, sector, m;
        int idx;
        res = '{1'b0, 5'd0, 6'd0, 19'd0};
        if (it.op == OP_READ) begin
            res.ring = it.rs;
            res.sector = it.ss;
            idx = int'(it.rs) * NUM_SECTORS + int'(it.ss);
            res.accepted = 1'b1;
            res.height = grid_model[idx];
            grid_model[idx] = '0;
            return res;
        end
        x = longint'(it.x);
        y = longint'(it.y);
        z = longint'(it.z);
        rings = model_rings;
        sectors = model_sectors;
        if (rings < 1) rings = 1;
        if (rings > NUM_RINGS) rings = NUM_RINGS;
        if (sectors < 1) sectors = 1;
        if (sectors > NUM_SECTORS) sectors = NUM_SECTORS;
        r2 = x * x + y * y;
        lim = longint'(model_radius) * longint'(model_radius);
        if (r2 == 0 || r2 >= lim) return res;
        lhs = r2 * rings * rings;
        ring = 0;
        for (longint k = rings - 1; k >= 1; k--) begin
            m = k * longint'(model_radius);
            if (m * m <= lhs) begin
                ring = k;
                break;
            end
        end
        sector = (phase_of(-x, -y) * sectors) >> 16;
        if (sector > sectors - 1) sector = sectors - 1;
        idx = int'(ring) * NUM_SECTORS + int'(sector);
        if (z > 0 && z > longint'(grid_model[idx])) grid_model[idx] = z[18:0];
        res.accepted = 1'b1;
        res.ring = ring[4:0];
        res.sector = sector[5:0];
        res.height = grid_model[idx];
        return res;
    endfunction

    task automatic send_point(point_item_t it, bit typed, cell_result_t typed_res);
        int r, gap;
        cell_result_t res;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {1'b0, it.ss, it.rs, it.z, it.y, it.x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = predict_cell(it);
        pending_cells = {pending_cells, (typed ? typed_res : res)};
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back; the caller
    // drops it after the last one.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_RING_COUNT:   model_rings = val[5:0];
            REG_SECTOR_COUNT: model_sectors = val[6:0];
            REG_MAX_RADIUS:   model_radius = val;
            default: ;
        endcase
    endtask

    function automatic point_item_t random_point();
        point_item_t it;
        int r, span, lim;
        it.op = OP_ACCUM;
        it.rs = 5'($urandom);
        it.ss = 6'($urandom);
        it.x = 20'($urandom);
        it.y = 20'($urandom);
        it.z = 20'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15) begin
            it.op = OP_READ;
            if ($urandom_range(0, 3) != 0) begin
                it.rs = 5'($urandom_range(0, (model_rings > 1 && model_rings <= 32)
                                                 ? model_rings - 1 : 31));
                it.ss = 6'($urandom_range(0, (model_sectors > 1 && model_sectors <= 64)
                                                 ? model_sectors - 1 : 63));
            end
            return it;
        end
        lim = (model_radius == 0) ? 1000 : int'(model_radius);
        if (r < 85) begin
            // Coordinates inside the square that bounds the radius limit.
            span = lim > 500000 ? 500000 : lim;
            it.x = 20'($urandom_range(0, 2 * span) - span);
            it.y = 20'($urandom_range(0, 2 * span) - span);
        end else if (r < 92) begin
            it.x = 20'($urandom_range(0, 6) - 3);
            it.y = 20'($urandom_range(0, 6) - 3);
        end
        if ($urandom_range(0, 9) < 7) it.z = 20'($urandom_range(0, 20000) - 2000);
        return it;
    endfunction

    // Receiver with random stalls and a long hold on request.
    initial begin
        int r;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end else if (quiet_mode) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(30, 100)) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cells.size() == 0) begin
                $error("result transaction with nothing expected");
                error_count++;
            end else begin
                want = pending_cells.pop_front();
                if (m_tuser !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, m_tuser);
                    error_count++;
                end
                if (m_tdata[4:0] !== want.ring) begin
                    $error("ring_index: expected %0d, got %0d", want.ring, m_tdata[4:0]);
                    error_count++;
                end
                if (m_tdata[10:5] !== want.sector) begin
                    $error("sector_index: expected %0d, got %0d", want.sector,
                           m_tdata[10:5]);
                    error_count++;
                end
                if (m_tdata[29:11] !== want.height) begin
                    $error("cell_height: expected %0d, got %0d", want.height,
                           m_tdata[29:11]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    table_row_t directed [$];

    function automatic void add_row(table_row_t t);
        directed = {directed, t};
    endfunction

    function automatic table_row_t row(logic op, int x, int y, int z, int rs, int ss,
                                       logic typed = 0, logic acc = 0, int ring = 0,
                                       int sector = 0, int height = 0);
        table_row_t t;
        t.item = '{op, 20'(x), 20'(y), 20'(z), 5'(rs), 6'(ss)};
        t.typed = typed;
        t.result = '{acc, 5'(ring), 6'(sector), 19'(height)};
        return t;
    endfunction

    // Register settings per random phase: rings, sectors, max radius.
    int phase_cfg [7][3] = '{'{20, 60, 80000}, '{1, 1, 1}, '{32, 64, 500000},
                             '{0, 0, 0}, '{63, 127, 524287}, '{7, 13, 1000},
                             '{40, 100, 3000}};

    initial begin
        point_item_t it;
        cell_result_t none;
        none = '{1'b0, 5'd0, 6'd0, 19'd0};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_ACCUM;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        model_rings   = 6'd20;
        model_sectors = 7'd60;
        model_radius  = 19'd80000;
        foreach (grid_model[i]) grid_model[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reads right after reset see cleared cells; skipped points report zeros.
        add_row(row(OP_READ, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
        add_row(row(OP_READ, 0, 0, 0, 31, 63, 1, 1, 31, 63, 0));
        add_row(row(OP_ACCUM, 0, 0, 500, 0, 0, 1));
        add_row(row(OP_ACCUM, 80000, 0, 500, 0, 0, 1));
        add_row(row(OP_ACCUM, 0, -80000, 500, 0, 0, 1));
        add_row(row(OP_ACCUM, -524288, -524288, 524287, 0, 0, 1));
        add_row(row(OP_ACCUM, 524287, 524287, -524288, 0, 0, 1));
        add_row(row(OP_ACCUM, 1, 0, 100, 0, 0));
        add_row(row(OP_ACCUM, 0, 1, 200, 0, 0));
        add_row(row(OP_ACCUM, -1, 0, 300, 0, 0));
        add_row(row(OP_ACCUM, 0, -1, 400, 0, 0));
        add_row(row(OP_ACCUM, 79999, 0, 524287, 0, 0));
        add_row(row(OP_ACCUM, 79999, 0, 1000, 0, 0));
        add_row(row(OP_ACCUM, 79999, 0, -524288, 0, 0));
        add_row(row(OP_ACCUM, 79999, 0, 0, 0, 0));
        add_row(row(OP_ACCUM, -40000, 40000, 7777, 0, 0));
        add_row(row(OP_ACCUM, 30000, -30000, 8888, 0, 0));
        add_row(row(OP_ACCUM, -56568, -56568, 9999, 0, 0));
        add_row(row(OP_ACCUM, 4000, 1, 50, 0, 0));
        add_row(row(OP_ACCUM, 4000, -1, 60, 0, 0));
        add_row(row(OP_READ, 0, 0, 0, 19, 30));
        add_row(row(OP_READ, 0, 0, 0, 19, 30));
        add_row(row(OP_READ, 0, 0, 0, 0, 30));
        add_row(row(OP_READ, 0, 0, 0, 25, 61));
        foreach (directed[i]) send_point(directed[i].item, directed[i].typed,
                                         directed[i].typed ? directed[i].result : none);
        wait_idle();
        // An index with no register behind it must change nothing.
        write_reg(2'd3, '1);

        for (int p = 0; p < 7; p++) begin
            write_reg(REG_RING_COUNT, CFG_DATA_W'(phase_cfg[p][0]));
            write_reg(REG_SECTOR_COUNT, CFG_DATA_W'(phase_cfg[p][1]));
            write_reg(REG_MAX_RADIUS, CFG_DATA_W'(phase_cfg[p][2]));
            cfg_valid <= 1'b0;
            quiet_mode = (p == 2);
            if (p == 1) begin
                // Hold the receiver long enough for the block to back up.
                long_hold = 1;
                for (int i = 0; i < 12; i++) begin
                    it = random_point();
                    send_point(it, 0, none);
                end
                wait_idle();
            end
            for (int i = 0; i < 255; i++) begin
                it = random_point();
                send_point(it, 0, none);
            end
            quiet_mode = 0;
            wait_idle();
        end

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
